// File: hw/rtl/bfgs_pkg.sv
// Package for the 2x2 BFGS inverse-Hessian update: widths, opcodes, register slots, micro-op program.
package bfgs_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int ProdWidth = 2 * DataWidth;
  localparam int QuoBits   = 2 * FracBits + 1;

  localparam logic signed [DataWidth-1:0] MaxVal = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic signed [DataWidth-1:0] OneVal =
    (FracBits >= DataWidth - 1) ? MaxVal : DataWidth'(64'sd1 <<< FracBits);

  typedef logic signed [DataWidth-1:0] word_t;

  // register file slots of the working set
  typedef enum logic [4:0] {
    R_S1  = 5'd0,  R_S2  = 5'd1,  R_Y1  = 5'd2,  R_Y2  = 5'd3,
    R_H11 = 5'd4,  R_H12 = 5'd5,  R_H21 = 5'd6,  R_H22 = 5'd7,
    R_RHO = 5'd8,  R_A11 = 5'd9,  R_A12 = 5'd10, R_A21 = 5'd11,
    R_A22 = 5'd12, R_T11 = 5'd13, R_T12 = 5'd14, R_T21 = 5'd15,
    R_T22 = 5'd16, R_TMP = 5'd17, R_P   = 5'd18, R_ONE = 5'd19,
    R_ZERO = 5'd20
  } reg_t;

  // micro-op kinds
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t  op;
    reg_t src_a;
    reg_t src_b;
    reg_t dst;
  } uop_t;

  localparam int NumUops = 45;
  localparam int PcWidth = $clog2(NumUops + 1);

  function automatic uop_t mk(op_t o, reg_t a, reg_t b, reg_t d);
    uop_t u;
    u.op = o; u.src_a = a; u.src_b = b; u.dst = d;
    return u;
  endfunction

  // Program after the dot product: rho, A, T = A*H, U = T*A^T, H = U + C
  function automatic uop_t prog(logic [PcWidth-1:0] pc);
    uop_t u;
    u = mk(OP_ADD, R_ZERO, R_ZERO, R_TMP);
    case (pc)
      6'd0:  u = mk(OP_DIV, R_P,   R_P,   R_RHO);
      6'd1:  u = mk(OP_MUL, R_S1,  R_Y1,  R_TMP);
      6'd2:  u = mk(OP_MUL, R_RHO, R_TMP, R_TMP);
      6'd3:  u = mk(OP_SUB, R_ONE, R_TMP, R_A11);
      6'd4:  u = mk(OP_MUL, R_S1,  R_Y2,  R_TMP);
      6'd5:  u = mk(OP_MUL, R_RHO, R_TMP, R_TMP);
      6'd6:  u = mk(OP_SUB, R_ZERO, R_TMP, R_A12);
      6'd7:  u = mk(OP_MUL, R_S2,  R_Y1,  R_TMP);
      6'd8:  u = mk(OP_MUL, R_RHO, R_TMP, R_TMP);
      6'd9:  u = mk(OP_SUB, R_ZERO, R_TMP, R_A21);
      6'd10: u = mk(OP_MUL, R_S2,  R_Y2,  R_TMP);
      6'd11: u = mk(OP_MUL, R_RHO, R_TMP, R_TMP);
      6'd12: u = mk(OP_SUB, R_ONE, R_TMP, R_A22);
      // T = A * H
      6'd13: u = mk(OP_MUL, R_A11, R_H11, R_TMP);
      6'd14: u = mk(OP_MUL, R_A12, R_H21, R_P);
      6'd15: u = mk(OP_ADD, R_TMP, R_P,   R_T11);
      6'd16: u = mk(OP_MUL, R_A11, R_H12, R_TMP);
      6'd17: u = mk(OP_MUL, R_A12, R_H22, R_P);
      6'd18: u = mk(OP_ADD, R_TMP, R_P,   R_T12);
      6'd19: u = mk(OP_MUL, R_A21, R_H11, R_TMP);
      6'd20: u = mk(OP_MUL, R_A22, R_H21, R_P);
      6'd21: u = mk(OP_ADD, R_TMP, R_P,   R_T21);
      6'd22: u = mk(OP_MUL, R_A21, R_H12, R_TMP);
      6'd23: u = mk(OP_MUL, R_A22, R_H22, R_P);
      6'd24: u = mk(OP_ADD, R_TMP, R_P,   R_T22);
      // U = T * A^T, H = U + rho*s*s^T
      6'd25: u = mk(OP_MUL, R_T11, R_A11, R_TMP);
      6'd26: u = mk(OP_MUL, R_T12, R_A12, R_P);
      6'd27: u = mk(OP_ADD, R_TMP, R_P,   R_H11);
      6'd28: u = mk(OP_MUL, R_T11, R_A21, R_TMP);
      6'd29: u = mk(OP_MUL, R_T12, R_A22, R_P);
      6'd30: u = mk(OP_ADD, R_TMP, R_P,   R_H12);
      6'd31: u = mk(OP_MUL, R_T21, R_A11, R_TMP);
      6'd32: u = mk(OP_MUL, R_T22, R_A12, R_P);
      6'd33: u = mk(OP_ADD, R_TMP, R_P,   R_H21);
      6'd34: u = mk(OP_MUL, R_T21, R_A21, R_TMP);
      6'd35: u = mk(OP_MUL, R_T22, R_A22, R_P);
      6'd36: u = mk(OP_ADD, R_TMP, R_P,   R_H22);
      6'd37: u = mk(OP_MUL, R_S1,  R_S1,  R_TMP);
      6'd38: u = mk(OP_MUL, R_RHO, R_TMP, R_TMP);
      6'd39: u = mk(OP_ADD, R_H11, R_TMP, R_H11);
      6'd40: u = mk(OP_MUL, R_S1,  R_S2,  R_TMP);
      6'd41: u = mk(OP_MUL, R_RHO, R_TMP, R_P);
      6'd42: u = mk(OP_ADD, R_H12, R_P,   R_H12);
      6'd43: u = mk(OP_ADD, R_H21, R_P,   R_H21);
      6'd44: u = mk(OP_MUL, R_S2,  R_S2,  R_TMP);
      6'd45: u = mk(OP_MUL, R_RHO, R_TMP, R_TMP);
      default: u = mk(OP_ADD, R_H22, R_TMP, R_H22);
    endcase
    return u;
  endfunction

endpackage

// File: hw/rtl/bfgs_inverse_hessian_update_2x2.sv
// 2x2 BFGS inverse-Hessian update on one shared multiply/add/divide unit.
// A request runs the dot product and check, then the reciprocal (issue, 33 quotient bits,
//   write) and the 46 other micro-ops, each issued and then executed; a degenerate request
//   goes straight to the output. A new request is taken only when idle, once the result
//   has been taken. Reset (rst, synchronous): H returns to identity, idle.
module bfgs_inverse_hessian_update_2x2 (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // step_x1, step_x2, grad_change_x1, grad_change_x2
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // h11, h12, h21, h22
  output logic [127:0] m_tdata,
  // degenerate
  output logic         m_tuser
);

  localparam int DW = bfgs_pkg::DataWidth;
  localparam int PW = bfgs_pkg::ProdWidth;
  localparam int FB = bfgs_pkg::FracBits;
  localparam int QB = bfgs_pkg::QuoBits;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DOT1 = 7'b0000010,
    ST_DOT2 = 7'b0000100,
    ST_CHK  = 7'b0001000,
    ST_ISS  = 7'b0010000,
    ST_EXE  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t state;
  logic [bfgs_pkg::PcWidth-1:0] pc;
  bfgs_pkg::word_t rf [21];
  bfgs_pkg::uop_t uop;
  bfgs_pkg::word_t opa, opb;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] mul_full;
  logic [5:0] div_cnt;
  logic [PW-1:0] div_rem, div_quo, div_mag;
  logic div_big, div_neg;

  // saturate a wide signed value to the data width
  function automatic bfgs_pkg::word_t sat(input logic signed [PW+1:0] v);
    if (v > (PW+2)'(bfgs_pkg::MaxVal)) return bfgs_pkg::MaxVal;
    if (v < (PW+2)'(bfgs_pkg::MinVal)) return bfgs_pkg::MinVal;
    return v[DW-1:0];
  endfunction

  // round half away from zero then saturate
  function automatic bfgs_pkg::word_t rnd(input logic signed [PW-1:0] p);
    logic [PW:0] m;
    logic [PW:0] r;
    logic signed [PW+1:0] v;
    m = p[PW-1] ? (PW+1)'(-{p[PW-1], p}) : (PW+1)'({1'b0, p});
    r = (m + ((PW+1)'(1) << (FB - 1))) >> FB;
    v = p[PW-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    return sat(v);
  endfunction

  assign uop = bfgs_pkg::prog(pc);
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata = {rf[bfgs_pkg::R_H22], rf[bfgs_pkg::R_H21],
                    rf[bfgs_pkg::R_H12], rf[bfgs_pkg::R_H11]};

  // the one multiplier, shared by the dot product and the micro-ops
  assign mul_full = opa * opb;

  // sequencer with shared unit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= '0;
      rf[bfgs_pkg::R_H11] <= bfgs_pkg::OneVal;
      rf[bfgs_pkg::R_H12] <= '0;
      rf[bfgs_pkg::R_H21] <= '0;
      rf[bfgs_pkg::R_H22] <= bfgs_pkg::OneVal;
      rf[bfgs_pkg::R_ONE] <= bfgs_pkg::OneVal;
      rf[bfgs_pkg::R_ZERO] <= '0;
      m_tuser <= 1'b0;
      div_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            rf[bfgs_pkg::R_S1] <= s_tdata[31:0];
            rf[bfgs_pkg::R_S2] <= s_tdata[63:32];
            rf[bfgs_pkg::R_Y1] <= s_tdata[95:64];
            rf[bfgs_pkg::R_Y2] <= s_tdata[127:96];
            opa <= s_tdata[95:64];
            opb <= s_tdata[31:0];
            state <= ST_DOT1;
          end
        end
        ST_DOT1: begin
          prod <= mul_full;
          opa <= rf[bfgs_pkg::R_Y2];
          opb <= rf[bfgs_pkg::R_S2];
          state <= ST_DOT2;
        end
        ST_DOT2: begin
          rf[bfgs_pkg::R_TMP] <= rnd(prod);
          prod <= mul_full;
          state <= ST_CHK;
        end
        ST_CHK: begin
          rf[bfgs_pkg::R_P] <= sat((PW+2)'(rf[bfgs_pkg::R_TMP]) + (PW+2)'(rnd(prod)));
          if (sat((PW+2)'(rf[bfgs_pkg::R_TMP]) + (PW+2)'(rnd(prod))) == '0) begin
            m_tuser <= 1'b1;
            state <= ST_OUT;
          end else begin
            m_tuser <= 1'b0;
            pc <= '0;
            state <= ST_ISS;
          end
        end
        ST_ISS: begin
          opa <= rf[uop.src_a];
          opb <= rf[uop.src_b];
          div_cnt <= '0;
          div_rem <= '0;
          div_quo <= '0;
          div_big <= 1'b0;
          div_neg <= rf[uop.src_a][DW-1];
          div_mag <= rf[uop.src_a][DW-1] ? PW'(-(PW'(rf[uop.src_a])))
                                          : PW'(rf[uop.src_a]);
          state <= ST_EXE;
        end
        ST_EXE: begin
          case (uop.op)
            bfgs_pkg::OP_MUL: begin
              rf[uop.dst] <= rnd(mul_full);
              pc <= pc + 1'b1;
              state <= ST_ISS;
            end
            bfgs_pkg::OP_ADD: begin
              rf[uop.dst] <= sat((PW+2)'(opa) + (PW+2)'(opb));
              pc <= pc + 1'b1;
              state <= (pc == bfgs_pkg::PcWidth'(bfgs_pkg::NumUops + 1)) ? ST_OUT
                                                                         : ST_ISS;
            end
            bfgs_pkg::OP_SUB: begin
              rf[uop.dst] <= sat((PW+2)'(opa) - (PW+2)'(opb));
              pc <= pc + 1'b1;
              state <= ST_ISS;
            end
            default: begin
              // restoring divide of 2^(2F) by |d|, one quotient bit a cycle
              if (div_cnt == 6'(QB)) begin
                if (div_big || div_quo > PW'(bfgs_pkg::MaxVal))
                  rf[uop.dst] <= div_neg ? bfgs_pkg::MinVal : bfgs_pkg::MaxVal;
                else
                  rf[uop.dst] <= div_neg ? DW'(-div_quo) : div_quo[DW-1:0];
                pc <= pc + 1'b1;
                state <= ST_ISS;
              end else begin
                if (div_quo[PW-1:PW-2] != 2'b00) div_big <= 1'b1;
                if ({div_rem[PW-2:0], (div_cnt == '0)} >= div_mag) begin
                  div_rem <= {div_rem[PW-2:0], (div_cnt == '0)} - div_mag;
                  div_quo <= {div_quo[PW-2:0], 1'b1};
                end else begin
                  div_rem <= {div_rem[PW-2:0], (div_cnt == '0)};
                  div_quo <= {div_quo[PW-2:0], 1'b0};
                end
                div_cnt <= div_cnt + 1'b1;
              end
            end
          endcase
        end
        ST_OUT: begin
          if (m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: tb/bfgs_inverse_hessian_update_2x2_test.sv
// Testbench for the 2x2 BFGS inverse-Hessian update: directed and random requests with a predictor.
module bfgs_inverse_hessian_update_2x2_test;

  typedef struct packed {
    bfgs_pkg::word_t h22, h21, h12, h11;
    logic  degen;
  } hess_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic         m_tuser;

  hess_t  hess_queue[$];
  longint hm[4];
  int     errors = 0;
  bit     hold_off = 1'b0;
  bit     send_done = 1'b0;

  bfgs_inverse_hessian_update_2x2 u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // run limit
  initial begin
    #40000000;
    $display("bfgs_inverse_hessian_update_2x2 test failed");
    $finish;
  end

  // saturate a wide value to the data width
  function automatic longint clamp(logic signed [129:0] v);
    if (v > 130'(bfgs_pkg::MaxVal)) return longint'(bfgs_pkg::MaxVal);
    if (v < 130'(bfgs_pkg::MinVal)) return longint'(bfgs_pkg::MinVal);
    return longint'(v);
  endfunction

  // fixed-point multiply, round half away from zero
  function automatic longint qmul(longint a, longint b);
    logic signed [129:0] p;
    logic        [129:0] m;
    p = 130'(a) * 130'(b);
    m = p < 0 ? -p : p;
    m = (m + (130'd1 << (bfgs_pkg::FracBits - 1))) >> bfgs_pkg::FracBits;
    return clamp(p < 0 ? -$signed(m) : $signed(m));
  endfunction

  function automatic longint qadd(longint a, longint b);
    return clamp(130'(a) + 130'(b));
  endfunction

  function automatic longint qsub(longint a, longint b);
    return clamp(130'(a) - 130'(b));
  endfunction

  // 2^(2F)/d truncated toward zero
  function automatic longint qrecip(longint d);
    logic signed [129:0] n;
    n = 130'sd1 <<< (2 * bfgs_pkg::FracBits);
    return clamp(n / 130'(d));
  endfunction

  // advance the held matrix by one request, return the expected result
  function automatic hess_t hess_update(bfgs_pkg::word_t s1, bfgs_pkg::word_t s2,
                                        bfgs_pkg::word_t y1, bfgs_pkg::word_t y2);
    longint s[2], y[2], a[4], t[4], u[4], d, rho;
    hess_t  r;
    s[0] = s1; s[1] = s2; y[0] = y1; y[1] = y2;
    d = qadd(qmul(y[0], s[0]), qmul(y[1], s[1]));
    r.degen = (d == 0);
    if (d != 0) begin
      rho = qrecip(d);
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          a[i*2+j] = qsub(i == j ? longint'(bfgs_pkg::OneVal) : 0,
                          qmul(rho, qmul(s[i], y[j])));
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          t[i*2+j] = qadd(qmul(a[i*2], hm[j]), qmul(a[i*2+1], hm[2+j]));
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          u[i*2+j] = qadd(qmul(t[i*2], a[j*2]), qmul(t[i*2+1], a[j*2+1]));
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          hm[i*2+j] = qadd(u[i*2+j], qmul(rho, qmul(s[i], s[j])));
    end
    r.h11 = bfgs_pkg::word_t'(hm[0]); r.h12 = bfgs_pkg::word_t'(hm[1]);
    r.h21 = bfgs_pkg::word_t'(hm[2]); r.h22 = bfgs_pkg::word_t'(hm[3]);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // send one request, predict at acceptance; valid stays up only when the next one follows
  task automatic send_request(bfgs_pkg::word_t s1, bfgs_pkg::word_t s2,
                              bfgs_pkg::word_t y1, bfgs_pkg::word_t y2, bit idle = 1'b1);
    int g;
    g = idle ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y2, y1, s2, s1};
    do @(posedge clk); while (!s_tready);
    hess_queue.push_back(hess_update(s1, s2, y1, y2));
    @(negedge clk);
  endtask

  // receiver ready pattern
  initial begin
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        @(negedge clk);
      end else if ($urandom_range(0, 99) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(20, 120)) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 9) < 8);
        @(negedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    hess_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (hess_queue.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[31:0], '0);
      end else begin
        w = hess_queue.pop_front();
        if (m_tdata[31:0]   !== w.h11) report_mismatch("h11", m_tdata[31:0], w.h11);
        if (m_tdata[63:32]  !== w.h12) report_mismatch("h12", m_tdata[63:32], w.h12);
        if (m_tdata[95:64]  !== w.h21) report_mismatch("h21", m_tdata[95:64], w.h21);
        if (m_tdata[127:96] !== w.h22) report_mismatch("h22", m_tdata[127:96], w.h22);
        if (m_tuser !== w.degen)
          report_mismatch("degenerate", {31'b0, m_tuser}, {31'b0, w.degen});
      end
    end
  end

  function automatic bfgs_pkg::word_t rand_word();
    case ($urandom_range(0, 5))
      0: return bfgs_pkg::word_t'($urandom);
      1: return bfgs_pkg::word_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      2: return $urandom_range(0, 1) ? bfgs_pkg::MaxVal : bfgs_pkg::MinVal;
      3: return bfgs_pkg::word_t'($signed($urandom_range(0, 32'h1ff)) - 32'sh100);
      default: return bfgs_pkg::word_t'($signed($urandom_range(0, 32'h7ffff)) - 32'sh3ffff);
    endcase
  endfunction

  // extremes, degenerate and tiny dot product, saturation
  task automatic test_directed();
    send_request(32'sh10000, 0, 32'sh10000, 0);
    send_request(0, 0, 0, 0);
    send_request(32'sh10000, 0, 0, 32'sh10000);
    send_request(1, 1, 1, 1);
    send_request(32'sh100, 0, -32'sh100, 0);
    send_request(32'sh20000, 32'sh10000, 32'sh10000, 32'sh30000);
    send_request(bfgs_pkg::MaxVal, bfgs_pkg::MaxVal, bfgs_pkg::MaxVal, bfgs_pkg::MaxVal);
    send_request(bfgs_pkg::MinVal, bfgs_pkg::MinVal, bfgs_pkg::MinVal, bfgs_pkg::MinVal);
    send_request(bfgs_pkg::MaxVal, bfgs_pkg::MinVal, bfgs_pkg::MinVal, bfgs_pkg::MaxVal);
    send_request(32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000);
    send_request(1, 0, 32'sh8000, 0);
    send_request(1, 0, 32'sh7fff, 0);
    send_request(-1, -1, -1, -1);
    send_request(32'sh8000, 32'sh8000, -32'sh8000, 32'sh4000);
    send_request(32'sh100000, 0, 1, 0);
    send_request(-32'sh30000, 32'sh18000, -32'sh20000, 32'sh10000);
  endtask

  // random requests, some noise
  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_request(rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 6; i++)
          send_request(rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);
      end
      begin
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  initial begin
    int w;
    hm[0] = bfgs_pkg::OneVal; hm[1] = 0; hm[2] = 0; hm[3] = bfgs_pkg::OneVal;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(1530);
    s_tvalid <= 1'b0;
    w = 0;
    while (hess_queue.size() != 0 && w < 100000) begin
      @(negedge clk);
      w++;
    end
    repeat (200) @(negedge clk);
    if (errors == 0 && hess_queue.size() == 0)
      $display("bfgs_inverse_hessian_update_2x2 test passed");
    else
      $display("bfgs_inverse_hessian_update_2x2 test failed");
    $finish;
  end
endmodule
